// File: rtl/core/nvhw_pkg.sv
// ----------------------------------------------------------------------------
// nvhw_pkg
// Shared types, character codes and helpers of the VHW sentence parser.
// ----------------------------------------------------------------------------
package nvhw_pkg;

  localparam int TERM_BYTES = 15;
  localparam int TLEN_W     = $clog2(TERM_BYTES + 1);
  localparam int MAG_W      = 28;
  localparam int FRAC_W     = 7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_W      = 8'h57;

  localparam logic [3:0] FIELD_KNOTS = 4'd5;
  localparam logic [3:0] FIELD_KMH   = 4'd7;
  localparam logic [3:0] FIELD_MAX   = 4'd15;

  // integer part at or above this saturates after scaling by 100
  localparam logic [MAG_W-1:0] MAG_SAT = MAG_W'(21474837);
  localparam logic [32:0]      POS_MAX = 33'h0_7FFF_FFFF;
  localparam logic [32:0]      NEG_MAX = 33'h0_8000_0000;

  typedef enum logic [1:0] {
    CMD_RESTART,
    CMD_CHAR,
    CMD_DELIM
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FIN
  } bk_state_t;

  typedef enum logic [2:0] {
    NP_WS,
    NP_INT,
    NP_F1,
    NP_F2,
    NP_F3,
    NP_DONE
  } np_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= 8'h41) && (c <= 8'h46)) v = c - 8'd55;
    else if ((c >= 8'h61) && (c <= 8'h66)) v = c - 8'd87;
    else v = c - CH_ZERO;
    return v;
  endfunction

endpackage

// File: rtl/core/nvhw_front.sv
// ----------------------------------------------------------------------------
// nvhw_front
// Accepts received bytes, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module nvhw_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_rx_byte,
  output logic          cmd_valid,
  output nvhw_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import nvhw_pkg::*;

  cmd_t       q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cls;

  always_comb begin
    cls.data = in_rx_byte;
    if (in_rx_byte == CH_DOLLAR || in_rx_byte == CH_BANG) begin
      cls.kind = CMD_RESTART;
    end else if (in_rx_byte == CH_COMMA || in_rx_byte == CH_CR ||
                 in_rx_byte == CH_LF || in_rx_byte == CH_STAR) begin
      cls.kind = CMD_DELIM;
    end else begin
      cls.kind = CMD_CHAR;
    end
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = cmd_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cls;
    end
  end

endmodule

// File: rtl/core/nvhw_back.sv
// ----------------------------------------------------------------------------
// nvhw_back
// Executes queued commands: term buffer, checksum, term walk and speed parse.
// ----------------------------------------------------------------------------
module nvhw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  nvhw_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_speed_knots_x100,
  output logic [31:0]    out_speed_kmh_x100
);
  import nvhw_pkg::*;

  bk_state_t          state_r, state_nxt;
  logic [7:0]         buf_r [TERM_BYTES];
  logic [TLEN_W-1:0]  len_r, k_r;
  logic [3:0]         field_r;
  logic [7:0]         xor_r, cur_r, c0_r, c1_r;
  logic               in_cs_r, ok_r, vhw_r, f0m_r;
  logic [31:0]        knots_r, kmh_r;
  np_state_t          np_r, np_nxt;
  logic               neg_r, neg_nxt, dig_r, dig_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic               f0m_nxt;
  logic               out_valid_r;
  logic [31:0]        out_kn_r, out_kh_r;

  logic [7:0]  ch;
  logic [3:0]  d;
  logic        walk_end, fin_go, hit, f0_vhw, negv, end_frac, out_load;
  logic [7:0]  cs, h0, h1;
  logic [32:0] t;
  logic [31:0] pv;

  assign ch       = buf_r[k_r];
  assign d        = ch[3:0];
  assign walk_end = (k_r == len_r) || (ch == CH_NUL);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_DELIM) state_nxt = BK_WALK;
      end
      BK_WALK: begin
        if (walk_end) state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (fin_go) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_pop = 1'b0;
    case (state_r)
      BK_IDLE: cmd_pop = cmd_valid;
      default: cmd_pop = 1'b0;
    endcase
  end

  // number scan, one term byte per cycle
  always_comb begin
    np_nxt   = np_r;
    neg_nxt  = neg_r;
    dig_nxt  = dig_r;
    mag_nxt  = mag_r;
    frac_nxt = frac_r;
    f0m_nxt  = f0m_r;
    end_frac = dig_r ? (ch == CH_DOT) : ((k_r == '0) && (ch == CH_DOT));
    case (k_r)
      TLEN_W'(0), TLEN_W'(1): if (!is_upper(ch)) f0m_nxt = 1'b0;
      TLEN_W'(2): if (ch != CH_V) f0m_nxt = 1'b0;
      TLEN_W'(3): if (ch != CH_H) f0m_nxt = 1'b0;
      TLEN_W'(4): if (ch != CH_W) f0m_nxt = 1'b0;
      default: ;
    endcase
    case (np_r)
      NP_WS: begin
        if (is_space(ch)) begin
          np_nxt = NP_WS;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
          neg_nxt = (ch == CH_MINUS);
          np_nxt  = NP_INT;
        end else if (is_digit(ch)) begin
          dig_nxt = 1'b1;
          mag_nxt = MAG_W'(d);
          np_nxt  = NP_INT;
        end else begin
          np_nxt = end_frac ? NP_F1 : NP_DONE;
        end
      end
      NP_INT: begin
        if (is_digit(ch)) begin
          dig_nxt = 1'b1;
          if (mag_r < MAG_SAT) mag_nxt = MAG_W'(mag_r * MAG_W'(10)) + MAG_W'(d);
        end else begin
          np_nxt = end_frac ? NP_F1 : NP_DONE;
        end
      end
      NP_F1: begin
        if (is_digit(ch)) begin
          frac_nxt = FRAC_W'(FRAC_W'(d) * FRAC_W'(10));
          np_nxt   = NP_F2;
        end else begin
          np_nxt = NP_DONE;
        end
      end
      NP_F2: begin
        if (is_digit(ch)) begin
          frac_nxt = frac_r + FRAC_W'(d);
          np_nxt   = NP_F3;
        end else begin
          np_nxt = NP_DONE;
        end
      end
      NP_F3: begin
        if (is_digit(ch) && d >= 4'd5) frac_nxt = frac_r + FRAC_W'(1);
        np_nxt = NP_DONE;
      end
      default: np_nxt = NP_DONE;
    endcase
  end

  // term completion
  always_comb begin
    h0     = hex_val(c0_r);
    h1     = hex_val(c1_r);
    cs     = {h0[3:0], 4'h0} + h1;
    hit    = in_cs_r && ok_r && (cs == xor_r);
    fin_go = !(hit && out_valid_r && out_stall);
    f0_vhw = f0m_r && (k_r == TLEN_W'(5));
    negv   = dig_r && neg_r;
    t      = 33'(mag_r) * 33'd100 + 33'(frac_r);
    if (mag_r >= MAG_SAT) begin
      pv = negv ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (!negv) begin
      pv = (t > POS_MAX) ? 32'h7FFF_FFFF : t[31:0];
    end else begin
      pv = (t > NEG_MAX) ? 32'h8000_0000 : 32'(-t);
    end
  end

  assign out_load = (state_r == BK_FIN) && fin_go && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      len_r       <= '0;
      k_r         <= '0;
      field_r     <= '0;
      xor_r       <= '0;
      in_cs_r     <= 1'b0;
      ok_r        <= 1'b0;
      vhw_r       <= 1'b0;
      knots_r     <= '0;
      kmh_r       <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        BK_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              CMD_RESTART: begin
                ok_r    <= 1'b0;
                field_r <= '0;
                len_r   <= '0;
                xor_r   <= '0;
                in_cs_r <= 1'b0;
              end
              CMD_CHAR: begin
                if (len_r < TLEN_W'(TERM_BYTES - 1)) len_r <= len_r + TLEN_W'(1);
                if (!in_cs_r) xor_r <= xor_r ^ cmd.data;
              end
              CMD_DELIM: begin
                if (cmd.data == CH_COMMA) xor_r <= xor_r ^ CH_COMMA;
                k_r <= '0;
              end
              default: ;
            endcase
          end
        end
        BK_WALK: begin
          if (!walk_end) k_r <= k_r + TLEN_W'(1);
        end
        BK_FIN: begin
          if (fin_go) begin
            if (!in_cs_r) begin
              if (field_r == '0) begin
                if (f0_vhw) begin
                  ok_r  <= 1'b1;
                  vhw_r <= 1'b1;
                end else begin
                  vhw_r <= 1'b0;
                end
              end else if (ok_r && vhw_r && k_r != '0) begin
                if (field_r == FIELD_KNOTS) knots_r <= pv;
                else if (field_r == FIELD_KMH) kmh_r <= pv;
              end
            end
            if (field_r != FIELD_MAX) field_r <= field_r + 4'd1;
            len_r   <= '0;
            in_cs_r <= (cur_r == CH_STAR);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kn_r <= knots_r;
      out_kh_r <= kmh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && cmd_valid) begin
      if (cmd.kind == CMD_CHAR && len_r < TLEN_W'(TERM_BYTES - 1)) begin
        buf_r[len_r] <= cmd.data;
      end
      cur_r  <= cmd.data;
      np_r   <= NP_WS;
      neg_r  <= 1'b0;
      dig_r  <= 1'b0;
      mag_r  <= '0;
      frac_r <= '0;
      f0m_r  <= 1'b1;
      c0_r   <= CH_NUL;
      c1_r   <= CH_NUL;
    end else if (state_r == BK_WALK && !walk_end) begin
      np_r   <= np_nxt;
      neg_r  <= neg_nxt;
      dig_r  <= dig_nxt;
      mag_r  <= mag_nxt;
      frac_r <= frac_nxt;
      f0m_r  <= f0m_nxt;
      if (k_r == TLEN_W'(0)) c0_r <= ch;
      if (k_r == TLEN_W'(1)) c1_r <= ch;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_speed_knots_x100 = out_kn_r;
  assign out_speed_kmh_x100   = out_kh_r;

endmodule

// File: rtl/core/nmea_vhw_sentence_parser_top.sv
// ----------------------------------------------------------------------------
// nmea_vhw_sentence_parser_top
// VHW sentence parser: byte front end, command queue and term executor.
// Ordinary bytes: one byte per cycle sustained while no delimiter is in the executor.
// Delimiters: term walk over n bytes (n = term length, at most 14), then completion,
// which out_stall can hold. Result: registered when the checksum term completes.
// Synchronous active-low reset clears the queue, parser state and output valid.
// ----------------------------------------------------------------------------
module nmea_vhw_sentence_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_speed_knots_x100,
  output logic signed [31:0] out_speed_kmh_x100
);
  import nvhw_pkg::*;

  logic  cmd_valid;
  cmd_t  cmd;
  logic  cmd_pop;
  logic [31:0] kn, kh;

  nvhw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  nvhw_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_pop              (cmd_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_speed_knots_x100 (kn),
    .out_speed_kmh_x100   (kh)
  );

  assign out_speed_knots_x100 = $signed(kn);
  assign out_speed_kmh_x100   = $signed(kh);

endmodule

// File: rtl/core/nvhw_checker.sv
// ----------------------------------------------------------------------------
// nvhw_checker
// Port-level checks of the VHW sentence parser, bound to the top level.
// ----------------------------------------------------------------------------
module nvhw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_speed_knots_x100,
  input logic [31:0] out_speed_kmh_x100
);

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_rx_byte))
    else $error("unknown input byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_speed_knots_x100) && $stable(out_speed_kmh_x100))
    else $error("stalled result changed");

endmodule

bind nmea_vhw_sentence_parser_top nvhw_checker u_nvhw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .in_rx_byte           (in_rx_byte),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_speed_knots_x100 (out_speed_knots_x100),
  .out_speed_kmh_x100   (out_speed_kmh_x100)
);
